// ===== rtl/core/rstg_pkg.sv =====
// Shared types and constants of the rectified sine tone generator.
// Used by rstg_core and rectified_sine_tone_generator; depends on nothing.

package rstg_pkg;

	localparam int PHASE_BITS_DEF     = 32;
	localparam int AMPLITUDE_BITS_DEF = 31;

	localparam int STEP_W   = 32;
	localparam int COUNT_W  = 24;
	localparam int SAMPLE_W = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_MASK = 2'd2;

	localparam logic [STEP_W-1:0]   PHASE_STEP_RST     = 32'd42852281;
	localparam logic [COUNT_W-1:0]  SAMPLE_COUNT_RST   = 24'd44100;
	localparam logic [SAMPLE_W-1:0] AMPLITUDE_MASK_RST = 31'h7FFF_FFFF;

	// Quarter-turn fold point and the angle scale pi * 2^30.
	localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;
	localparam logic [31:0] PI_Q30       = 32'd3373259426;
	localparam logic [31:0] ONE_Q31      = 32'h8000_0000;

	// Horner divisors of the sine series and floor(2^34 / divisor).
	localparam int HORNER_TERMS = 8;
	localparam logic [2:0] LAST_TERM = 3'd7;
	localparam logic [8:0] HORNER_DIV [HORNER_TERMS] = '{
		9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
	};
	localparam logic [31:0] HORNER_RECIP [HORNER_TERMS] = '{
		32'd63161283, 32'd81808900, 32'd110127366, 32'd156180628,
		32'd238609294, 32'd409044504, 32'd858993459, 32'd2863311530
	};

	typedef struct packed {
		logic go;
		logic out_free;
	} rstg_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} rstg_stat_t;

endpackage

// ===== rtl/core/rstg_core.sv =====
// Microcoded sine magnitude unit: one shared 33x32 multiplier driven by a
// read-only control program with a step counter. Depends on rstg_pkg.

module rstg_core #(
	parameter int AMPLITUDE_BITS = rstg_pkg::AMPLITUDE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rstg_pkg::rstg_ctl_t   ctl,
	input  logic [30:0]           x,
	output rstg_pkg::rstg_stat_t  stat,
	output logic [rstg_pkg::SAMPLE_W-1:0] mag
);

	typedef enum logic [2:0] {
		A_ZERO, A_X, A_RVIEW, A_R2, A_QVIEW, A_EST, A_R, A_S
	} asel_t;

	typedef enum logic [2:0] {
		B_ZERO, B_PI, B_RVIEW, B_T, B_RECIP, B_K, B_FULL
	} bsel_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_WAIT_IN, OP_WR_R, OP_INIT, OP_WR_Q, OP_WR_EST, OP_UPD_T,
		OP_WR_S, OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		SQ_NEXT, SQ_LOOP, SQ_RET
	} seq_t;

	typedef struct packed {
		asel_t      a;
		bsel_t      b;
		logic       mul_en;
		op_t        op;
		seq_t       seq;
		logic [3:0] target;
	} uword_t;

	localparam logic [3:0] STEP_LOOP = 4'd4;
	localparam logic [31:0] FULL = 32'((64'd1 << AMPLITUDE_BITS) - 64'd1);

	function automatic uword_t ucode(input logic [3:0] pc);
		uword_t w;
		w.a      = A_ZERO;
		w.b      = B_ZERO;
		w.mul_en = 1'b0;
		w.op     = OP_NONE;
		w.seq    = SQ_NEXT;
		w.target = STEP_LOOP;
		unique case (pc)
			4'd0: begin
				w.op = OP_WAIT_IN;
			end
			4'd1: begin
				w.a = A_X; w.b = B_PI; w.mul_en = 1'b1;
			end
			4'd2: begin
				w.a = A_RVIEW; w.b = B_RVIEW; w.mul_en = 1'b1; w.op = OP_WR_R;
			end
			4'd3: begin
				w.op = OP_INIT;
			end
			4'd4: begin
				w.a = A_R2; w.b = B_T; w.mul_en = 1'b1;
			end
			4'd5: begin
				w.a = A_QVIEW; w.b = B_RECIP; w.mul_en = 1'b1; w.op = OP_WR_Q;
			end
			4'd6: begin
				w.a = A_EST; w.b = B_K; w.mul_en = 1'b1; w.op = OP_WR_EST;
			end
			4'd7: begin
				w.op = OP_UPD_T; w.seq = SQ_LOOP;
			end
			4'd8: begin
				w.a = A_R; w.b = B_T; w.mul_en = 1'b1;
			end
			4'd9: begin
				w.op = OP_WR_S;
			end
			4'd10: begin
				w.a = A_S; w.b = B_FULL; w.mul_en = 1'b1;
			end
			4'd11: begin
				w.op = OP_OUT; w.seq = SQ_RET;
			end
			default: begin
				w.seq = SQ_RET;
			end
		endcase
		return w;
	endfunction

	logic [3:0]  upc_q;
	logic [2:0]  k_q;
	logic [30:0] x_q;
	logic [31:0] r_q;
	logic [32:0] r2_q;
	logic [31:0] t_q;
	logic [32:0] q_q;
	logic [30:0] est_q;
	logic [64:0] prod_q;

	uword_t      uw;
	logic        hold;
	logic [31:0] rview;
	logic [32:0] qview;
	logic [30:0] estview;
	logic [31:0] sview;
	logic [32:0] op_a;
	logic [31:0] op_b;
	logic [32:0] rem;
	logic        corr;
	logic [31:0] est_fix;
	logic [31:0] t_new;

	assign uw      = ucode(upc_q);
	assign rview   = prod_q[61:30];
	assign qview   = prod_q[63:31];
	assign estview = prod_q[64:34];
	assign sview   = (qview > {1'b0, rstg_pkg::ONE_Q31}) ? rstg_pkg::ONE_Q31 : qview[31:0];

	assign rem     = q_q - prod_q[32:0];
	assign corr    = (rem >= {24'd0, rstg_pkg::HORNER_DIV[k_q]});
	assign est_fix = {1'b0, est_q} + {31'd0, corr};
	assign t_new   = rstg_pkg::ONE_Q31 - est_fix;

	assign hold = ((uw.op == OP_WAIT_IN) && !ctl.go) || ((uw.op == OP_OUT) && !ctl.out_free);

	always_comb begin
		case (uw.a)
			A_X:     op_a = {2'd0, x_q};
			A_RVIEW: op_a = {1'b0, rview};
			A_R2:    op_a = r2_q;
			A_QVIEW: op_a = qview;
			A_EST:   op_a = {2'd0, estview};
			A_R:     op_a = {1'b0, r_q};
			A_S:     op_a = q_q;
			default: op_a = '0;
		endcase
		case (uw.b)
			B_PI:    op_b = rstg_pkg::PI_Q30;
			B_RVIEW: op_b = rview;
			B_T:     op_b = t_q;
			B_RECIP: op_b = rstg_pkg::HORNER_RECIP[k_q];
			B_K:     op_b = {23'd0, rstg_pkg::HORNER_DIV[k_q]};
			B_FULL:  op_b = FULL;
			default: op_b = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= '0;
			k_q   <= '0;
		end else begin
			if (!hold) begin
				unique case (uw.seq)
					SQ_NEXT: upc_q <= upc_q + 4'd1;
					SQ_LOOP: upc_q <= (k_q != rstg_pkg::LAST_TERM) ? uw.target : upc_q + 4'd1;
					SQ_RET:  upc_q <= '0;
					default: upc_q <= '0;
				endcase
			end
			if (uw.op == OP_INIT) begin
				k_q <= '0;
			end else if (uw.op == OP_UPD_T) begin
				k_q <= k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uw.mul_en) begin
			prod_q <= 65'(op_a) * 65'(op_b);
		end
		case (uw.op)
			OP_WAIT_IN: begin
				if (ctl.go) begin
					x_q <= x;
				end
			end
			OP_WR_R:   r_q <= rview;
			OP_INIT: begin
				r2_q <= qview;
				t_q  <= rstg_pkg::ONE_Q31;
			end
			OP_WR_Q:   q_q <= qview;
			OP_WR_EST: est_q <= estview;
			OP_UPD_T:  t_q <= t_new;
			OP_WR_S:   q_q <= {1'b0, sview};
			default: ;
		endcase
	end

	assign mag       = rstg_pkg::SAMPLE_W'(prod_q[AMPLITUDE_BITS+30:31]);
	assign stat.idle = (uw.op == OP_WAIT_IN);
	assign stat.done = (uw.op == OP_OUT) && ctl.out_free;

endmodule

// ===== rtl/core/rectified_sine_tone_generator.sv =====
// Top level of the rectified sine tone generator: configuration registers,
// phase accumulator, sample counter and output register. Uses rstg_core, rstg_pkg.
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_wr_en             cfg_index, cfg_wr_data
//   in        in         in_valid / in_ready   start_req
//   out       out        out_valid / out_ready sample, last_sample
//
// Per tick the shared multiplier in rstg_core runs a 12-step program whose
// Horner loop repeats 4 steps for 8 series terms. The result is registered
// at the last step, which stalls while the output holds an untaken sample; the
// next input is taken in the following cycle, even while that result waits.
// Reset clears the phase, the sample index and the program counter.

module rectified_sine_tone_generator #(
	parameter int PHASE_BITS     = rstg_pkg::PHASE_BITS_DEF,
	parameter int AMPLITUDE_BITS = rstg_pkg::AMPLITUDE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rstg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rstg_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               start_req,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rstg_pkg::SAMPLE_W-1:0]      sample,
	output logic                               last_sample
);

	logic [rstg_pkg::STEP_W-1:0]   phase_step_q;
	logic [rstg_pkg::COUNT_W-1:0]  sample_count_q;
	logic [rstg_pkg::SAMPLE_W-1:0] amplitude_mask_q;
	logic [PHASE_BITS-1:0]         acc_q;
	logic [rstg_pkg::COUNT_W-1:0]  idx_q;
	logic                          last_pend_q;
	logic                          out_valid_q;
	logic [rstg_pkg::SAMPLE_W-1:0] sample_q;
	logic                          last_q;

	logic [PHASE_BITS-1:0]         ph_cur;
	logic [PHASE_BITS+31:0]        ph_ext;
	logic [PHASE_BITS+31:0]        st_ext;
	logic [PHASE_BITS-1:0]         step_scaled;
	logic [31:0]                   p;
	logic [30:0]                   h;
	logic [30:0]                   x;
	logic [rstg_pkg::COUNT_W-1:0]  idx_cur;
	logic                          is_last;
	logic                          in_xfer;
	rstg_pkg::rstg_ctl_t           ctl;
	rstg_pkg::rstg_stat_t          stat;
	logic [rstg_pkg::SAMPLE_W-1:0] mag;

	assign in_ready = stat.idle;
	assign in_xfer  = in_valid && in_ready;

	assign ph_cur      = start_req ? '0 : acc_q;
	assign ph_ext      = {ph_cur, 32'd0};
	assign p           = ph_ext[PHASE_BITS+31:PHASE_BITS];
	assign st_ext      = {phase_step_q, {PHASE_BITS{1'b0}}};
	assign step_scaled = st_ext[PHASE_BITS+31:32];
	assign h           = p[30:0];
	assign x           = (h <= rstg_pkg::QUARTER_TURN) ? h : (~h + 31'd1);

	assign idx_cur = start_req ? '0 : idx_q;
	assign is_last = (idx_cur == (sample_count_q - 24'd1));

	assign ctl.go       = in_xfer;
	assign ctl.out_free = !out_valid_q || out_ready;

	rstg_core #(
		.AMPLITUDE_BITS(AMPLITUDE_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.x     (x),
		.stat  (stat),
		.mag   (mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q     <= rstg_pkg::PHASE_STEP_RST;
			sample_count_q   <= rstg_pkg::SAMPLE_COUNT_RST;
			amplitude_mask_q <= rstg_pkg::AMPLITUDE_MASK_RST;
			acc_q            <= '0;
			idx_q            <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					rstg_pkg::REG_PHASE_STEP:     phase_step_q <= cfg_wr_data;
					rstg_pkg::REG_SAMPLE_COUNT:   sample_count_q <= cfg_wr_data[23:0];
					rstg_pkg::REG_AMPLITUDE_MASK: amplitude_mask_q <= cfg_wr_data[30:0];
					default: ;
				endcase
			end
			if (in_xfer) begin
				acc_q <= ph_cur + step_scaled;
				idx_q <= is_last ? '0 : idx_cur + 24'd1;
			end
			if (stat.done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			last_pend_q <= is_last;
		end
		if (stat.done) begin
			sample_q <= mag & amplitude_mask_q;
			last_q   <= last_pend_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign last_sample = last_q;

endmodule
